// File: rtl/core/first_fit_track_allocator_core_macros.svh
// Assertion macros used by the first-fit track allocator core.
`ifndef FIRST_FIT_TRACK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_TRACK_ALLOCATOR_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FFTAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FFTAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/fftac_pkg.sv
// Shared constants and types for the first-fit track allocator.
package fftac_pkg;

  // Store depth and coordinate width.
  localparam int MAX_INTERVALS = 256;
  localparam int COORD_BITS    = 16;

  // Derived widths: track index, counts that can reach the depth itself.
  localparam int TRK_W = (MAX_INTERVALS > 2) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

  // Port field widths.
  localparam int TRK_OUT_W  = 8;
  localparam int CNT_OUT_W  = 9;
  localparam int IN_DATA_W  = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_FLD_W  = TRK_OUT_W + 1 + CNT_OUT_W + 1;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // Request kinds carried on the input tuser.
  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // Free-track search works on one chunk of the busy map per cycle.
  localparam int CHUNK_W    = (MAX_INTERVALS < 16) ? MAX_INTERVALS : 16;
  localparam int NUM_CHUNKS = (MAX_INTERVALS + CHUNK_W - 1) / CHUNK_W;
  localparam int MAP_W      = NUM_CHUNKS * CHUNK_W;
  localparam int CHK_IDX_W  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int CHK_POS_W  = (CHUNK_W > 1) ? $clog2(CHUNK_W) : 1;
  localparam int BASE_W     = CNT_W + CHK_POS_W + 1;

  // One stored interval.
  typedef struct packed {
    logic [TRK_W-1:0]      track;
    logic [COORD_BITS-1:0] right;
    logic [COORD_BITS-1:0] left;
  } entry_t;

  // Result of the free-track search, valid in the cycle when done is high.
  typedef struct packed {
    logic             done;
    logic             opened;
    logic [TRK_W-1:0] track;
  } srch_t;

endpackage

// File: rtl/core/fftac_interval_ram.sv
// Interval store: one write port and one registered read port.
module fftac_interval_ram (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [fftac_pkg::TRK_W-1:0] wr_addr,
  input  fftac_pkg::entry_t           wr_data,
  input  logic                        rd_en,
  input  logic [fftac_pkg::TRK_W-1:0] rd_addr,
  output fftac_pkg::entry_t           rd_data
);
  import fftac_pkg::*;

  entry_t mem [MAX_INTERVALS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/fftac_busy_map.sv
// Busy-track bitmap and chunked search for the lowest free track.
module fftac_busy_map (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clr,
  input  logic                        set_en,
  input  logic [fftac_pkg::TRK_W-1:0] set_idx,
  input  logic                        srch_en,
  input  logic [fftac_pkg::CNT_W-1:0] tracks,
  output fftac_pkg::srch_t            srch
);
  import fftac_pkg::*;

  logic [MAP_W-1:0]     map;
  logic [CHK_IDX_W-1:0] chunk;
  logic [BASE_W-1:0]    base;
  logic [CHUNK_W-1:0]   bits;
  logic [CHUNK_W-1:0]   free;
  logic                 found;
  logic [CHK_POS_W-1:0] pos;
  logic                 last;

  // Bitmap: cleared when each request is accepted, marked during the scan.
  always_ff @(posedge clk) begin
    if (clr) begin
      map <= '0;
    end else if (set_en) begin
      map[set_idx] <= 1'b1;
    end
  end

  // Chunk pointer walks the map until the search finishes.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      chunk <= '0;
    end else if (srch_en && !srch.done) begin
      chunk <= chunk + 1'b1;
    end
  end

  // Look for the lowest track below the in-use count that is not busy.
  always_comb begin
    base  = BASE_W'(chunk) * BASE_W'(CHUNK_W);
    bits  = map[int'(chunk) * CHUNK_W +: CHUNK_W];
    found = 1'b0;
    pos   = '0;
    for (int j = 0; j < CHUNK_W; j++) begin
      free[j] = !bits[j] && ((base + BASE_W'(j)) < BASE_W'(tracks));
    end
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      if (free[j]) begin
        found = 1'b1;
        pos   = CHK_POS_W'(j);
      end
    end
    last = ((base + BASE_W'(CHUNK_W)) >= BASE_W'(tracks)) ||
           (chunk == CHK_IDX_W'(NUM_CHUNKS - 1));
    srch.done   = srch_en && (found || last);
    srch.opened = !found;
    srch.track  = found ? TRK_W'(base + BASE_W'(pos)) : TRK_W'(tracks);
  end

endmodule

// File: rtl/core/first_fit_track_allocator_core.sv
// Top level of the first-fit track allocator: request sequencer and result register.
//
//  Channel   Dir  Handshake          Payload
//  s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: min_input_x, max_input_x, source_x
//  m_*       out  m_tvalid/m_tready  tdata: track_number, opened_track, track_count, store_full
//
// A clear or a request on a full store goes straight from idle to the result state.
// An allocation passes through the scan state, which reads the stored intervals one per
// cycle into the busy map, and the search state, which walks the map in groups of 16 tracks
// from the lowest up to the first free one. The result state loads the output register and
// returns to idle, so a new request is taken only after the last result is loaded. A result
// waiting on m_tready holds the sequencer in its result state. The store needs no clearing
// after rst; only entries below the interval count are read.
module first_fit_track_allocator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: min_input_x, max_input_x, source_x (from bit 0 up)
  input  logic [fftac_pkg::IN_DATA_W-1:0] s_tdata,
  // s_tuser: req_type
  input  logic [0:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: track_number, opened_track, track_count, store_full, zero fill (from bit 0 up)
  output logic [fftac_pkg::OUT_DATA_W-1:0] m_tdata
);
  import fftac_pkg::*;
  `include "first_fit_track_allocator_core_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      tracks;
  logic [CNT_W-1:0]      rd_idx;
  logic                  rd_vld;
  logic [COORD_BITS-1:0] lo;
  logic [COORD_BITS-1:0] hi;
  logic [TRK_W-1:0]      res_track;
  logic                  res_opened;
  logic                  res_full;
  logic                  res_store;

  logic                  accept;
  logic [COORD_BITS-1:0] in_min;
  logic [COORD_BITS-1:0] in_max;
  logic [COORD_BITS-1:0] in_src;
  logic [COORD_BITS-1:0] lo_next;
  logic [COORD_BITS-1:0] hi_next;
  logic                  rd_en;
  logic                  wr_en;
  logic                  out_free;
  logic                  overlap;
  entry_t                wr_data;
  entry_t                rd_data;
  srch_t                 srch;

  // Input fields and span widening by the source coordinate.
  assign in_min = s_tdata[COORD_BITS-1:0];
  assign in_max = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_src = s_tdata[3*COORD_BITS-1:2*COORD_BITS];

  always_comb begin
    lo_next = in_min;
    hi_next = in_max;
    if (in_src < in_min) begin
      lo_next = in_src;
    end else if (in_src > in_max) begin
      hi_next = in_src;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Store traffic: reads only while scanning, the write only when the result is issued.
  assign rd_en   = (state == ST_SCAN) && (rd_idx < count);
  assign wr_en   = (state == ST_RESULT) && out_free && res_store;
  assign wr_data = '{track: res_track, right: hi, left: lo};

  fftac_interval_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[TRK_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[TRK_W-1:0]),
    .rd_data (rd_data)
  );

  // A stored interval blocks its track unless one span ends before the other begins.
  assign overlap = !((hi < rd_data.left) || (lo > rd_data.right));

  fftac_busy_map u_map (
    .clk     (clk),
    .rst     (rst),
    .clr     (accept),
    .set_en  (rd_vld && overlap),
    .set_idx (rd_data.track),
    .srch_en (state == ST_SEARCH),
    .tracks  (tracks),
    .srch    (srch)
  );

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      tracks <= '0;
      rd_idx <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (rd_en) begin
        rd_idx <= rd_idx + 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            rd_idx <= '0;
            if (s_tuser[0] == REQ_CLEAR) begin
              count  <= '0;
              tracks <= '0;
              state  <= ST_RESULT;
            end else if (count == CNT_W'(MAX_INTERVALS)) begin
              state <= ST_RESULT;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!rd_en && !rd_vld) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (srch.done) begin
            tracks <= tracks + CNT_W'(srch.opened);
            state  <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            count <= count + CNT_W'(res_store);
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Pending result and the span of the request in progress.
  always_ff @(posedge clk) begin
    if (accept) begin
      lo         <= lo_next;
      hi         <= hi_next;
      res_track  <= '0;
      res_opened <= 1'b0;
      res_store  <= 1'b0;
      res_full   <= (s_tuser[0] == REQ_ALLOC) && (count == CNT_W'(MAX_INTERVALS));
    end else if ((state == ST_SEARCH) && srch.done) begin
      res_track  <= srch.track;
      res_opened <= srch.opened;
      res_store  <= 1'b1;
    end
  end

  // Output register: a transfer clears it, a finished request loads it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_RESULT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESULT) && out_free) begin
      m_tdata <= OUT_DATA_W'({res_full, CNT_OUT_W'(tracks), res_opened,
                              TRK_OUT_W'(res_track)});
    end
  end

  // Between requests, every track in use holds at least one stored interval.
  `FFTAC_ASSERT_NOW(a_tracks_le_count, state == ST_IDLE, tracks <= count, "track count above interval count")
  // The store is never read and written in the same cycle.
  `FFTAC_ASSERT_NOW(a_no_rd_wr_overlap, rd_en || rd_vld, !wr_en, "store read overlaps write-back")
  // All scan reads have been folded into the busy map before the search runs.
  `FFTAC_ASSERT_NOW(a_scan_drained, state == ST_SEARCH, !rd_vld, "search started with a read in flight")
  // An accepted request keeps the input closed for at least the next cycle.
  `FFTAC_ASSERT_NEXT(a_one_at_a_time, accept, !s_tready, "second request taken while busy")
  // The interval count never passes the store depth.
  `FFTAC_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_INTERVALS), "interval count beyond store depth")

endmodule

// File: sim/track_placement_checker.sv
// Checker for the first-fit track allocator: predicts every placement and compares results.
module track_placement_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [fftac_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [0:0]                       s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [fftac_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                               error_count,
  output int                               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import fftac_pkg::*;

  // Result fields, listed from the highest bit down so the struct matches m_tdata.
  typedef struct packed {
    logic                 store_full;
    logic [CNT_OUT_W-1:0] track_count;
    logic                 opened_track;
    logic [TRK_OUT_W-1:0] track_number;
  } placement_t;

  // Shadow copy of the interval store and the two counters.
  logic [COORD_BITS-1:0] span_left  [MAX_INTERVALS];
  logic [COORD_BITS-1:0] span_right [MAX_INTERVALS];
  int                    span_track [MAX_INTERVALS];
  int                    stored_count;
  int                    open_tracks;

  // Expected placements in transfer order.
  placement_t pending_placements[$];

  // Works out the placement of one request and updates the shadow store.
  function automatic placement_t predict_placement(logic kind, logic [COORD_BITS-1:0] sink_lo,
                                                   logic [COORD_BITS-1:0] sink_hi,
                                                   logic [COORD_BITS-1:0] src);
    logic [COORD_BITS-1:0] lo;
    logic [COORD_BITS-1:0] hi;
    logic [MAX_INTERVALS:0] busy;
    int                     trk;
    placement_t             res;
    res = '0;
    if (kind == REQ_CLEAR) begin
      stored_count = 0;
      open_tracks  = 0;
      return res;
    end
    // A full store leaves everything as it was and flags the request.
    if (stored_count >= MAX_INTERVALS) begin
      res.track_count = open_tracks[CNT_OUT_W-1:0];
      res.store_full  = 1'b1;
      return res;
    end
    // Widen the span to take in the source; inverted bounds are kept as given.
    lo = sink_lo;
    hi = sink_hi;
    if (src < lo) begin
      lo = src;
    end else if (src > hi) begin
      hi = src;
    end
    // Mark every track that holds an overlapping interval (inclusive bounds).
    busy = '0;
    for (int i = 0; i < stored_count; i++) begin
      if (!(hi < span_left[i] || lo > span_right[i])) begin
        busy[span_track[i]] = 1'b1;
      end
    end
    // Lowest free track, or a new one when all are blocked.
    trk = 0;
    while (trk < open_tracks && busy[trk]) begin
      trk++;
    end
    if (trk >= open_tracks) begin
      trk = open_tracks;
      open_tracks++;
      res.opened_track = 1'b1;
    end
    span_left[stored_count]  = lo;
    span_right[stored_count] = hi;
    span_track[stored_count] = trk;
    stored_count++;
    res.track_number = trk[TRK_OUT_W-1:0];
    res.track_count  = open_tracks[CNT_OUT_W-1:0];
    return res;
  endfunction

  // Compares one field of a result and reports a difference.
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Record accepted requests and match each result transfer against the oldest expectation.
  always @(posedge clk) begin
    placement_t got;
    placement_t want;
    if (rst) begin
      stored_count = 0;
      open_tracks  = 0;
      pending_placements.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        pending_placements.push_back(predict_placement(s_tuser[0],
                                                       s_tdata[COORD_BITS-1:0],
                                                       s_tdata[2*COORD_BITS-1:COORD_BITS],
                                                       s_tdata[3*COORD_BITS-1:2*COORD_BITS]));
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(placement_t)-1:0];
        if (pending_placements.size() == 0) begin
          $display("%0t: result with nothing expected, actual track %0d opened %0d count %0d full %0d",
                   $time, got.track_number, got.opened_track, got.track_count, got.store_full);
          error_count++;
        end else begin
          want = pending_placements.pop_front();
          check_field("track_number", 16'(want.track_number), 16'(got.track_number));
          check_field("opened_track", 16'(want.opened_track), 16'(got.opened_track));
          check_field("track_count", 16'(want.track_count), 16'(got.track_count));
          check_field("store_full", 16'(want.store_full), 16'(got.store_full));
        end
      end
    end
    pending_count = pending_placements.size();
  end

endmodule

// File: sim/testbench.sv
// Top of the first-fit track allocator testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fftac_pkg::*;

  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int RANDOM_REQS = 1950;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_WAIT  = 300;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = REQ_CLEAR;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    error_count;
  int                    pending_count;
  int                    results_taken = 0;

  first_fit_track_allocator_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  track_placement_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  // Free-running clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Count result transfers so the receiver knows when to apply back-pressure.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      results_taken <= results_taken + 1;
    end
  end

  // Receiver: random stalls, quiet stretches, and two long hold-offs that fill the block.
  initial begin
    int stall_left;
    int calm_left;
    int pick;
    bit first_hold;
    bit second_hold;
    stall_left  = 0;
    calm_left   = 0;
    first_hold  = 1'b0;
    second_hold = 1'b0;
    forever begin
      @(negedge clk);
      if (!first_hold && results_taken >= 120) begin
        first_hold = 1'b1;
        stall_left = 600;
      end else if (!second_hold && results_taken >= 1400) begin
        second_hold = 1'b1;
        stall_left = 600;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 199) == 0) begin
          calm_left = $urandom_range(200, 600);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick >= 97) begin
            stall_left = $urandom_range(20, 100);
          end else if (pick >= 75) begin
            stall_left = $urandom_range(1, 3);
          end
        end
      end
    end
  end

  int calm_items = 0;

  // Clips a computed coordinate into the legal range.
  function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
    if (v < 0) begin
      return '0;
    end else if (v > COORD_MAX) begin
      return COORD_MAX[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

  // Offers one request, waits for its transfer, then idles for a random gap.
  task automatic send_request(logic kind, logic [COORD_BITS-1:0] sink_lo,
                              logic [COORD_BITS-1:0] sink_hi, logic [COORD_BITS-1:0] src);
    int gap;
    int pick;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {src, sink_hi, sink_lo};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    gap = 0;
    if (calm_items > 0) begin
      calm_items--;
    end else if ($urandom_range(0, 99) == 0) begin
      calm_items = $urandom_range(20, 80);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick >= 95) begin
        gap = $urandom_range(20, 100);
      end else if (pick >= 60) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Reset, directed requests, random layers of requests, drain and verdict.
  initial begin
    int sent;
    int seq_len;
    int mode;
    int long_seqs;
    int width;
    int base;
    int center;
    logic [COORD_BITS-1:0] lo;
    logic [COORD_BITS-1:0] hi;
    logic [COORD_BITS-1:0] src;
    logic [COORD_BITS-1:0] tmp;
    logic kind;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: touching and disjoint spans, source widening, inverted and extreme bounds.
    send_request(REQ_ALLOC, 16'd100, 16'd200, 16'd150);
    send_request(REQ_ALLOC, 16'd200, 16'd300, 16'd250);
    send_request(REQ_ALLOC, 16'd301, 16'd400, 16'd350);
    send_request(REQ_ALLOC, 16'd50, 16'd99, 16'd10);
    send_request(REQ_ALLOC, 16'd500, 16'd600, 16'd700);
    send_request(REQ_ALLOC, 16'd900, 16'd800, 16'd850);
    send_request(REQ_ALLOC, 16'd1000, 16'd950, 16'd2000);
    send_request(REQ_ALLOC, 16'd0, 16'd0, 16'd0);
    send_request(REQ_ALLOC, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(REQ_ALLOC, 16'd0, 16'hFFFF, 16'h8000);
    send_request(REQ_ALLOC, 16'hFFFF, 16'd0, 16'd0);
    send_request(REQ_ALLOC, 16'hFFFF, 16'd0, 16'hFFFF);
    send_request(REQ_ALLOC, 16'd100, 16'd200, 16'd150);
    send_request(REQ_CLEAR, 16'd0, 16'd0, 16'd0);
    send_request(REQ_ALLOC, 16'd0, 16'hFFFF, 16'd0);
    send_request(REQ_ALLOC, 16'd0, 16'hFFFF, 16'hFFFF);
    send_request(REQ_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(REQ_CLEAR, 16'h5555, 16'hAAAA, 16'h1234);
    send_request(REQ_ALLOC, 16'd7, 16'd7, 16'd7);

    // Random part: layers that usually start with a clear, a few of them long enough to fill the store.
    sent      = 0;
    long_seqs = 0;
    while (sent < RANDOM_REQS) begin
      if ($urandom_range(0, 7) == 0) begin
        seq_len = $urandom_range(258, 272);
        mode    = (2 + long_seqs) % 4;
        long_seqs++;
      end else begin
        seq_len = $urandom_range(1, 30);
        mode    = $urandom_range(0, 3);
      end
      width  = 1 << $urandom_range(4, 12);
      base   = $urandom_range(0, COORD_MAX - width);
      center = $urandom_range(0, COORD_MAX);
      // Occasionally a layer starts without its clear.
      if ($urandom_range(0, 9) != 0) begin
        send_request(REQ_CLEAR, COORD_BITS'($urandom_range(0, COORD_MAX)),
                     COORD_BITS'($urandom_range(0, COORD_MAX)),
                     COORD_BITS'($urandom_range(0, COORD_MAX)));
        sent++;
      end
      for (int k = 0; k < seq_len && sent < RANDOM_REQS; k++) begin
        kind = REQ_ALLOC;
        if ($urandom_range(0, 19) == 0) begin
          // Noise: any kind, any coordinates.
          kind = 1'($urandom_range(0, 1));
          lo   = COORD_BITS'($urandom_range(0, COORD_MAX));
          hi   = COORD_BITS'($urandom_range(0, COORD_MAX));
          src  = COORD_BITS'($urandom_range(0, COORD_MAX));
        end else begin
          case (mode)
            0: begin
              lo  = COORD_BITS'($urandom_range(0, COORD_MAX));
              hi  = COORD_BITS'($urandom_range(0, COORD_MAX));
              src = COORD_BITS'($urandom_range(0, COORD_MAX));
            end
            1: begin
              lo  = COORD_BITS'(base + $urandom_range(0, width - 1));
              hi  = clamp_coord(int'(lo) + $urandom_range(0, width / 4));
              src = COORD_BITS'(base + $urandom_range(0, width - 1));
            end
            2: begin
              // Spans gather around one point, so most of them need a fresh track.
              lo  = clamp_coord(center - $urandom_range(0, 100));
              hi  = clamp_coord(center + $urandom_range(0, 100));
              src = center[COORD_BITS-1:0];
            end
            default: begin
              lo  = COORD_BITS'($urandom_range(0, 63));
              hi  = COORD_BITS'($urandom_range(0, 63));
              src = COORD_BITS'($urandom_range(0, 63));
            end
          endcase
          if (mode != 0 && $urandom_range(0, 9) == 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
        end
        send_request(kind, lo, hi, src);
        sent++;
      end
    end
    s_tvalid <= 1'b0;

    // Drain the outstanding results, then let the block settle.
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/fftac_pkg.sv
rtl/core/fftac_interval_ram.sv
rtl/core/fftac_busy_map.sv
rtl/core/first_fit_track_allocator_core.sv
sim/track_placement_checker.sv
sim/testbench.sv
